/* sv/rhc_pkg.sv */
// shared types and constants for the rgb to hsv converter
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    // channel and result field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;

    // width of the hue multiplier operand, at most 6 * delta
    localparam int X_W = 11;

    // default hue fraction and the matching divider depth
    localparam int HUE_FRACTION_BITS_DEF = 6;
    localparam int DIV_STAGES_DEF        = $clog2(360 * (1 << HUE_FRACTION_BITS_DEF));

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // data that rides alongside the divider lanes
    typedef struct packed {
        logic            grey;
        logic [CH_W-1:0] brightness;
    } side_t;

endpackage

`default_nettype wire

/* sv/rhc_div_lane.sv */
// pipelined restoring divider lane, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_lane #(
    parameter int STAGES = rhc_pkg::DIV_STAGES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic [STAGES+rhc_pkg::CH_W-1:0]    num,
    input  wire logic [rhc_pkg::CH_W-1:0]           den,
    output logic      [STAGES-1:0]                  quo
);

    localparam int DW = rhc_pkg::CH_W;

    // numerator must be below den * 2^STAGES, so the top bits start below den
    logic [DW-1:0]     rem_reg [STAGES-1];
    logic [DW-1:0]     den_reg [STAGES-1];
    // remaining numerator bits shift out the top, quotient bits shift in below
    logic [STAGES-1:0] work_reg [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [DW-1:0]     rem_in;
        logic [DW-1:0]     den_in;
        logic [STAGES-1:0] work_in;
        logic [DW:0]       trial;
        logic              ge;
        logic [DW-1:0]     rem_next;
        logic [STAGES-1:0] work_next;

        if (j == 0) begin : g_first
            assign rem_in  = num[STAGES+DW-1:STAGES];
            assign den_in  = den;
            assign work_in = num[STAGES-1:0];
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign work_in = work_reg[j-1];
        end

        always_comb begin
            trial     = {rem_in, work_in[STAGES-1]};
            ge        = trial >= {1'b0, den_in};
            rem_next  = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            work_next = {work_in[STAGES-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[j] <= work_next;
            end
        end

        if (j < STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = work_reg[STAGES-1];

endmodule

`default_nettype wire

/* sv/rgb_to_hsv_converter.sv */
// rgb to hsv converter: three front stages, two divider lanes, output skid register
// throughput: one word per cycle while the skid register is empty
// depth is set by the hue divider, one quotient bit a stage
// an empty skid register lets the pipeline drain one word into it when m_ready is low
// reset (aresetn low, synchronous) clears the valid bits and the skid; data regs are not reset
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rhc_pkg::CH_W-1:0]    s_red,
    input  wire logic [rhc_pkg::CH_W-1:0]    s_green,
    input  wire logic [rhc_pkg::CH_W-1:0]    s_blue,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rhc_pkg::HUE_W-1:0]        m_hue,
    output logic [rhc_pkg::CH_W-1:0]         m_saturation,
    output logic [rhc_pkg::CH_W-1:0]         m_brightness
);

    localparam int CW         = rhc_pkg::CH_W;
    localparam int XW         = rhc_pkg::X_W;
    localparam int HW         = rhc_pkg::HUE_W;
    localparam int DIV_STAGES = $clog2(360 * (1 << HUE_FRACTION_BITS));
    localparam int NW         = DIV_STAGES + CW;
    localparam int NS         = 3 + DIV_STAGES;
    localparam logic [NW-1:0] HUE_K = NW'(60) << HUE_FRACTION_BITS;
    localparam logic [NW-1:0] SAT_K = NW'(255);

    logic                 en;
    logic [NS-1:0]        vld_reg;
    logic [NS-1:0]        vld_next;

    // stage 0: max, min, sector
    logic [CW-1:0]        red0_reg, green0_reg, blue0_reg, max0_reg, min0_reg;
    rhc_pkg::sector_t     sect0_reg;
    logic [CW-1:0]        max0_next, min0_next;
    rhc_pkg::sector_t     sect0_next;

    // stage 1: delta and hue operand
    logic [CW-1:0]        delta1_reg, max1_reg;
    logic [XW-1:0]        x1_reg;
    logic [CW-1:0]        delta1_next;
    logic [XW-1:0]        x1_next;
    logic [XW-1:0]        d11;

    // stage 2: numerators
    logic [NW-1:0]        hnum2_reg, snum2_reg;
    logic [CW-1:0]        delta2_reg, max2_reg;

    // divider stages
    rhc_pkg::side_t       side_reg [DIV_STAGES];
    rhc_pkg::side_t       side_in;
    logic [DIV_STAGES-1:0] hue_quo, sat_quo;

    // result and skid
    logic [HW-1:0]        hue_fin;
    logic [CW-1:0]        sat_fin;
    logic                 skid_full_reg, skid_full_next;
    logic [HW-1:0]        skid_hue_reg;
    logic [CW-1:0]        skid_sat_reg, skid_bright_reg;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    // valid bits follow the data
    always_comb begin
        vld_next = {vld_reg[NS-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // stage 0
    always_comb begin
        max0_next = s_red;
        min0_next = s_red;
        if (s_green > max0_next) max0_next = s_green;
        if (s_blue > max0_next)  max0_next = s_blue;
        if (s_green < min0_next) min0_next = s_green;
        if (s_blue < min0_next)  min0_next = s_blue;
        // ties go to red, then green
        if (s_red >= s_green && s_red >= s_blue) begin
            sect0_next = rhc_pkg::SECT_RED;
        end else if (s_green >= s_blue) begin
            sect0_next = rhc_pkg::SECT_GREEN;
        end else begin
            sect0_next = rhc_pkg::SECT_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red0_reg   <= s_red;
            green0_reg <= s_green;
            blue0_reg  <= s_blue;
            max0_reg   <= max0_next;
            min0_reg   <= min0_next;
            sect0_reg  <= sect0_next;
        end
    end

    // stage 1: hue operand, always in 0 .. 6*delta
    always_comb begin
        delta1_next = max0_reg - min0_reg;
        d11         = XW'(delta1_next);
        case (sect0_reg)
            rhc_pkg::SECT_RED: begin
                if (green0_reg >= blue0_reg) begin
                    x1_next = XW'(green0_reg) - XW'(blue0_reg);
                end else begin
                    // negative red sector wraps by a full turn
                    x1_next = (d11 << 2) + (d11 << 1) - XW'(blue0_reg) + XW'(green0_reg);
                end
            end
            rhc_pkg::SECT_GREEN: x1_next = XW'(blue0_reg) + (d11 << 1) - XW'(red0_reg);
            rhc_pkg::SECT_BLUE:  x1_next = XW'(red0_reg) + (d11 << 2) - XW'(green0_reg);
            default:             x1_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta1_reg <= delta1_next;
            max1_reg   <= max0_reg;
            x1_reg     <= x1_next;
        end
    end

    // stage 2: scale to the divider numerators
    always_ff @(posedge aclk) begin
        if (en) begin
            hnum2_reg  <= NW'(NW'(x1_reg) * HUE_K);
            snum2_reg  <= NW'(NW'(delta1_reg) * SAT_K);
            delta2_reg <= delta1_reg;
            max2_reg   <= max1_reg;
        end
    end

    // divider lanes
    rhc_div_lane #(
        .STAGES (DIV_STAGES)
    ) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (hnum2_reg),
        .den  (delta2_reg),
        .quo  (hue_quo)
    );

    rhc_div_lane #(
        .STAGES (DIV_STAGES)
    ) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (snum2_reg),
        .den  (max2_reg),
        .quo  (sat_quo)
    );

    // grey pixel (also covers black) forces hue and saturation to zero
    always_comb begin
        side_in.grey       = (delta2_reg == '0);
        side_in.brightness = max2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int j = 1; j < DIV_STAGES; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb begin
        hue_fin = side_reg[DIV_STAGES-1].grey ? '0 : HW'(hue_quo);
        sat_fin = side_reg[DIV_STAGES-1].grey ? '0 : CW'(sat_quo);
    end

    // skid register takes the last word when the sink stalls
    always_comb begin
        if (skid_full_reg) begin
            skid_full_next = !m_ready;
        end else begin
            skid_full_next = vld_reg[NS-1] && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg) begin
            skid_hue_reg    <= hue_fin;
            skid_sat_reg    <= sat_fin;
            skid_bright_reg <= side_reg[DIV_STAGES-1].brightness;
        end
    end

    assign m_valid      = skid_full_reg || vld_reg[NS-1];
    assign m_hue        = skid_full_reg ? skid_hue_reg : hue_fin;
    assign m_saturation = skid_full_reg ? skid_sat_reg : sat_fin;
    assign m_brightness = skid_full_reg ? skid_bright_reg : side_reg[DIV_STAGES-1].brightness;

endmodule

`default_nettype wire
